/* rtl/hmm_pkg.sv */
package hmm_pkg;

  // event kinds
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_MALLOC       = 3'd0;
  localparam logic [2:0] CFG_MALLOC_REENT = 3'd1;
  localparam logic [2:0] CFG_CALLOC       = 3'd2;
  localparam logic [2:0] CFG_REALLOC      = 3'd3;
  localparam logic [2:0] CFG_REALLOC_REENT = 3'd4;
  localparam logic [2:0] CFG_FREE         = 3'd5;
  localparam logic [2:0] CFG_FREE_REENT   = 3'd6;

  // table steps, run in this order within one event
  localparam int unsigned NUM_STEPS = 12;
  localparam logic [3:0] STEP_M_PUT   = 4'd0;
  localparam logic [3:0] STEP_M_PURGE = 4'd1;
  localparam logic [3:0] STEP_C_PUT   = 4'd2;
  localparam logic [3:0] STEP_C_PURGE = 4'd3;
  localparam logic [3:0] STEP_R_DROP  = 4'd4;
  localparam logic [3:0] STEP_R_PUT   = 4'd5;
  localparam logic [3:0] STEP_R_PURGE = 4'd6;
  localparam logic [3:0] STEP_F_HAS   = 4'd7;
  localparam logic [3:0] STEP_F_DROPA = 4'd8;
  localparam logic [3:0] STEP_F_ADD   = 4'd9;
  localparam logic [3:0] STEP_W_HAS   = 4'd10;
  localparam logic [3:0] STEP_W_GUARD = 4'd11;

  localparam logic [31:0] GUARD_OFS = 32'd4;
  localparam logic [6:0]  GUARD_MAX = 7'd127;

  typedef struct packed {
    logic       accept;
    logic       plan;
    logic       clear;
    logic       scan_start;
    logic       scan;
    logic       write;
    logic       fin;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic [NUM_STEPS-1:0] mask;
    logic                 found;
    logic                 scan_last;
    logic                 clear_last;
    logic                 out_free;
  } stat_t;

endpackage

/* rtl/hmm_ctrl.sv */
module hmm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hmm_pkg::stat_t stat_i,
  output hmm_pkg::cmd_t  cmd_o
);
  import hmm_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PLAN  = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [NUM_STEPS-1:0] mask_q, mask_d;
  logic [3:0]           step_q, step_d;
  logic [NUM_STEPS-1:0] avail;
  logic [3:0]           pick;
  logic                 any;

  // steps still to run; release steps are skipped after a double free
  always_comb begin
    avail = mask_q;
    if (stat_i.found) begin
      avail[STEP_F_DROPA] = 1'b0;
      avail[STEP_F_ADD]   = 1'b0;
    end
    pick = 4'd0;
    any  = |avail;
    for (int i = NUM_STEPS - 1; i >= 0; i--) begin
      if (avail[i]) pick = 4'(i);
    end
  end

  always_comb begin
    state_d = state_q;
    mask_d  = mask_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        mask_d  = stat_i.mask;
        state_d = S_PICK;
      end
      S_PICK: begin
        if (any) begin
          step_d           = pick;
          cmd_o.step       = pick;
          cmd_o.scan_start = 1'b1;
          mask_d[pick]     = 1'b0;
          state_d          = S_SCAN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          if (step_q inside {STEP_M_PUT, STEP_C_PUT, STEP_R_PUT, STEP_F_ADD}) begin
            state_d = S_WRITE;
          end else begin
            state_d = S_PICK;
          end
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = S_PICK;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.fin = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      mask_q  <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      mask_q  <= mask_d;
      step_q  <= step_d;
    end
  end

endmodule

/* rtl/hmm_datapath.sv */
module hmm_datapath #(
  parameter int unsigned ALLOC_ENTRIES = 64,
  parameter int unsigned FREED_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hmm_pkg::cmd_t  cmd_i,
  output hmm_pkg::stat_t stat_o,
  input  logic           cfg_valid_i,
  input  logic [2:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i,
  input  logic [1:0]     op_i,
  input  logic [31:0]    pc_i,
  input  logic [31:0]    link_reg_i,
  input  logic [31:0]    arg0_i,
  input  logic [31:0]    arg1_i,
  input  logic [31:0]    arg2_i,
  input  logic [31:0]    write_addr_i,
  input  logic           out_stall_i,
  output logic           out_valid_o,
  output logic           double_free_o,
  output logic           use_after_free_o,
  output logic [6:0]     guard_hits_o,
  output logic [31:0]    report_addr_o,
  output logic [31:0]    report_pc_o,
  output logic [31:0]    report_lr_o,
  output logic           table_full_o
);
  import hmm_pkg::*;

  localparam int unsigned AW   = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
  localparam int unsigned FW   = (FREED_ENTRIES > 1) ? $clog2(FREED_ENTRIES) : 1;
  localparam int unsigned IW   = (AW > FW) ? AW : FW;
  localparam int unsigned CW   = IW + 1;
  localparam int unsigned MAXN = (ALLOC_ENTRIES > FREED_ENTRIES) ? ALLOC_ENTRIES
                                                                  : FREED_ENTRIES;

  // configuration registers
  logic [31:0] e_mal_q, e_malr_q, e_cal_q, e_real_q, e_realr_q, e_free_q, e_freer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_mal_q <= '0; e_malr_q <= '0; e_cal_q <= '0; e_real_q <= '0;
      e_realr_q <= '0; e_free_q <= '0; e_freer_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MALLOC:        e_mal_q   <= cfg_data_i;
        CFG_MALLOC_REENT:  e_malr_q  <= cfg_data_i;
        CFG_CALLOC:        e_cal_q   <= cfg_data_i;
        CFG_REALLOC:       e_real_q  <= cfg_data_i;
        CFG_REALLOC_REENT: e_realr_q <= cfg_data_i;
        CFG_FREE:          e_free_q  <= cfg_data_i;
        CFG_FREE_REENT:    e_freer_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // latched event
  logic [1:0]  op_q;
  logic [31:0] pc_q, lr_q, a0_q, a1_q, a2_q, wa_q, wa_p4_q, wa_m4_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q <= op_i; pc_q <= pc_i; lr_q <= link_reg_i;
      a0_q <= arg0_i; a1_q <= arg1_i; a2_q <= arg2_i; wa_q <= write_addr_i;
      wa_p4_q <= write_addr_i + GUARD_OFS;
      wa_m4_q <= write_addr_i - GUARD_OFS;
    end
  end

  // pending calls
  logic        mal_pend_q, cal_pend_q, real_pend_q, fre_pend_q;
  logic [31:0] pm_ret_q, pm_size_q, pc_ret_q, pc_size_q;
  logic [31:0] pr_ret_q, pr_old_q, pr_size_q, pf_ret_q, pf_obj_q;
  logic [3:0]  comp_q;
  logic        h_mal, h_malr, h_cal, h_real, h_realr, h_free, h_freer;
  logic [31:0] ret;
  logic        c_mal, c_cal, c_real, c_free, any_pend;
  logic [NUM_STEPS-1:0] step_mask;

  assign h_mal   = (e_mal_q != '0)   && (e_mal_q == pc_q);
  assign h_malr  = (e_malr_q != '0)  && (e_malr_q == pc_q);
  assign h_cal   = (e_cal_q != '0)   && (e_cal_q == pc_q);
  assign h_real  = (e_real_q != '0)  && (e_real_q == pc_q);
  assign h_realr = (e_realr_q != '0) && (e_realr_q == pc_q);
  assign h_free  = (e_free_q != '0)  && (e_free_q == pc_q);
  assign h_freer = (e_freer_q != '0) && (e_freer_q == pc_q);
  assign ret     = {lr_q[31:1], 1'b0};

  assign c_mal    = (op_q == OP_END) && mal_pend_q  && (pc_q == pm_ret_q);
  assign c_cal    = (op_q == OP_END) && cal_pend_q  && (pc_q == pc_ret_q);
  assign c_real   = (op_q == OP_END) && real_pend_q && (pc_q == pr_ret_q);
  assign c_free   = (op_q == OP_END) && fre_pend_q  && (pc_q == pf_ret_q);
  assign any_pend = mal_pend_q | cal_pend_q | real_pend_q | fre_pend_q;

  // steps this event needs
  always_comb begin
    step_mask = '0;
    if (c_mal) begin
      step_mask[STEP_M_PUT] = 1'b1; step_mask[STEP_M_PURGE] = 1'b1;
    end
    if (c_cal) begin
      step_mask[STEP_C_PUT] = 1'b1; step_mask[STEP_C_PURGE] = 1'b1;
    end
    if (c_real) begin
      step_mask[STEP_R_DROP] = 1'b1; step_mask[STEP_R_PUT] = 1'b1;
      step_mask[STEP_R_PURGE] = 1'b1;
    end
    if (c_free && pf_obj_q != '0) begin
      step_mask[STEP_F_HAS] = 1'b1; step_mask[STEP_F_DROPA] = 1'b1;
      step_mask[STEP_F_ADD] = 1'b1;
    end
    if (op_q == OP_WRITE && !any_pend) begin
      step_mask[STEP_W_HAS] = 1'b1; step_mask[STEP_W_GUARD] = 1'b1;
    end
  end

  // block starts update at plan time; completions clear at finish
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mal_pend_q <= 1'b0; cal_pend_q <= 1'b0; real_pend_q <= 1'b0; fre_pend_q <= 1'b0;
      pm_ret_q <= '0; pm_size_q <= '0; pc_ret_q <= '0; pc_size_q <= '0;
      pr_ret_q <= '0; pr_old_q <= '0; pr_size_q <= '0; pf_ret_q <= '0; pf_obj_q <= '0;
      comp_q <= '0;
    end else if (cmd_i.plan) begin
      comp_q <= {c_free, c_real, c_cal, c_mal};
      if (op_q == OP_START) begin
        if (h_mal || (h_malr && !mal_pend_q)) begin
          mal_pend_q <= 1'b1; pm_ret_q <= ret;
          pm_size_q  <= h_mal ? a0_q : a1_q;
        end
        if (h_cal) begin
          cal_pend_q <= 1'b1; pc_ret_q <= ret;
          pc_size_q  <= a0_q * a1_q;
        end
        if (h_real || (h_realr && !real_pend_q)) begin
          real_pend_q <= 1'b1; pr_ret_q <= ret;
          pr_old_q  <= h_real ? a0_q : a1_q;
          pr_size_q <= h_real ? a1_q : a2_q;
        end
        if (h_free || (h_freer && !fre_pend_q)) begin
          fre_pend_q <= 1'b1; pf_ret_q <= ret;
          pf_obj_q   <= h_free ? a0_q : a1_q;
        end
      end
    end else if (cmd_i.fin) begin
      if (comp_q[0]) begin mal_pend_q <= 1'b0; pm_ret_q <= '0; pm_size_q <= '0; end
      if (comp_q[1]) begin cal_pend_q <= 1'b0; pc_ret_q <= '0; pc_size_q <= '0; end
      if (comp_q[2]) begin
        real_pend_q <= 1'b0; pr_ret_q <= '0; pr_old_q <= '0; pr_size_q <= '0;
      end
      if (comp_q[3]) begin fre_pend_q <= 1'b0; pf_ret_q <= '0; pf_obj_q <= '0; end
    end
  end

  // step operands
  logic [31:0] key, len;
  logic        is_alloc, is_put, is_purge, is_adrop, is_has, is_add, is_guard;
  logic [CW-1:0] n_sel;

  always_comb begin
    key = a0_q;
    len = '0;
    case (cmd_i.step)
      STEP_M_PUT, STEP_M_PURGE: len = pm_size_q;
      STEP_C_PUT, STEP_C_PURGE: len = pc_size_q;
      STEP_R_DROP:              key = pr_old_q;
      STEP_R_PUT, STEP_R_PURGE: len = pr_size_q;
      STEP_F_HAS, STEP_F_DROPA, STEP_F_ADD: key = pf_obj_q;
      STEP_W_HAS, STEP_W_GUARD: key = wa_q;
      default: ;
    endcase
  end

  assign is_put   = cmd_i.step inside {STEP_M_PUT, STEP_C_PUT, STEP_R_PUT};
  assign is_purge = cmd_i.step inside {STEP_M_PURGE, STEP_C_PURGE, STEP_R_PURGE};
  assign is_adrop = cmd_i.step inside {STEP_R_DROP, STEP_F_DROPA};
  assign is_has   = cmd_i.step inside {STEP_F_HAS, STEP_W_HAS};
  assign is_add   = (cmd_i.step == STEP_F_ADD);
  assign is_guard = (cmd_i.step == STEP_W_GUARD);
  assign is_alloc = is_put | is_adrop | is_guard;
  assign n_sel    = is_alloc ? CW'(ALLOC_ENTRIES) : CW'(FREED_ENTRIES);

  // table memories: alloc word {valid, base, length}, freed word {valid, base}
  logic [64:0] a_mem [ALLOC_ENTRIES];
  logic [32:0] f_mem [FREED_ENTRIES];
  logic [64:0] a_rd_q, a_wdata;
  logic [32:0] f_rd_q, f_wdata;
  logic        a_we, f_we;
  logic [AW-1:0] a_waddr;
  logic [FW-1:0] f_waddr;

  // scan sequencing
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] ridx_q;
  logic          rvld_q, issue;
  logic          scan_last, clear_last, out_free;

  assign issue = cmd_i.scan && (cnt_q < n_sel);

  always_ff @(posedge clk_i) begin
    if (a_we) a_mem[a_waddr] <= a_wdata;
    a_rd_q <= a_mem[cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) f_mem[f_waddr] <= f_wdata;
    f_rd_q <= f_mem[cnt_q[FW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rvld_q <= 1'b0;
      ridx_q <= '0;
    end else if (cmd_i.scan_start) begin
      cnt_q  <= '0;
      rvld_q <= 1'b0;
    end else if (cmd_i.clear) begin
      cnt_q <= cnt_q + 1'b1;
    end else begin
      rvld_q <= issue;
      ridx_q <= cnt_q[IW-1:0];
      if (issue) cnt_q <= cnt_q + 1'b1;
    end
  end

  assign scan_last  = cmd_i.scan && rvld_q && ({1'b0, ridx_q} == n_sel - 1'b1);
  assign clear_last = (cnt_q == CW'(MAXN - 1));

  // per entry checks
  logic        a_v, f_v, proc;
  logic [31:0] a_b, a_l, f_b;
  logic [32:0] purge_end;

  assign a_v  = a_rd_q[64];
  assign a_b  = a_rd_q[63:32];
  assign a_l  = a_rd_q[31:0];
  assign f_v  = f_rd_q[32];
  assign f_b  = f_rd_q[31:0];
  assign proc = cmd_i.scan && rvld_q;
  assign purge_end = {1'b0, key} + {1'b0, len};

  logic          found_q, full_q, mfound_q, ffound_q;
  logic [IW-1:0] midx_q, fidx_q;
  logic [6:0]    guards_q;

  // table writes
  always_comb begin
    a_we = 1'b0; a_waddr = ridx_q[AW-1:0]; a_wdata = {1'b0, a_b, a_l};
    f_we = 1'b0; f_waddr = ridx_q[FW-1:0]; f_wdata = {1'b0, f_b};
    if (cmd_i.clear) begin
      a_we = (cnt_q < CW'(ALLOC_ENTRIES)); a_waddr = cnt_q[AW-1:0]; a_wdata = '0;
      f_we = (cnt_q < CW'(FREED_ENTRIES)); f_waddr = cnt_q[FW-1:0]; f_wdata = '0;
    end else if (proc) begin
      if (is_adrop && a_v && a_b == key) a_we = 1'b1;
      if (is_purge && f_v && f_b >= key && {1'b0, f_b} < purge_end) f_we = 1'b1;
    end else if (cmd_i.write) begin
      if (is_put) begin
        a_wdata = {1'b1, key, len};
        a_we    = mfound_q | ffound_q;
        a_waddr = mfound_q ? midx_q[AW-1:0] : fidx_q[AW-1:0];
      end
      if (is_add) begin
        f_wdata = {1'b1, key};
        f_we    = ffound_q;
        f_waddr = fidx_q[FW-1:0];
      end
    end
  end

  // scan trackers and event flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0; full_q <= 1'b0; mfound_q <= 1'b0; ffound_q <= 1'b0;
      midx_q <= '0; fidx_q <= '0; guards_q <= '0;
    end else if (cmd_i.plan) begin
      found_q <= 1'b0; full_q <= 1'b0; guards_q <= '0;
    end else if (cmd_i.scan_start) begin
      mfound_q <= 1'b0; ffound_q <= 1'b0;
    end else if (proc) begin
      if (is_put && a_v && a_b == key && !mfound_q) begin
        mfound_q <= 1'b1; midx_q <= ridx_q;
      end
      if (is_put && !a_v && !ffound_q) begin
        ffound_q <= 1'b1; fidx_q <= ridx_q;
      end
      if (is_add && !f_v && !ffound_q) begin
        ffound_q <= 1'b1; fidx_q <= ridx_q;
      end
      if (is_has && f_v && f_b == key) found_q <= 1'b1;
      if (is_guard && a_v && (a_b == wa_p4_q || a_b + a_l == wa_m4_q) &&
          guards_q != GUARD_MAX) begin
        guards_q <= guards_q + 1'b1;
      end
    end else if (cmd_i.write) begin
      if ((is_put && !mfound_q && !ffound_q) || (is_add && !ffound_q)) full_q <= 1'b1;
    end
  end

  assign out_free = !out_valid_o || !out_stall_i;

  // status to the controller
  assign stat_o = '{mask: step_mask, found: found_q, scan_last: scan_last,
                    clear_last: clear_last, out_free: out_free};

  // result register
  logic dfree, uaf;
  assign dfree = (op_q == OP_END) && found_q;
  assign uaf   = (op_q == OP_WRITE) && found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_o <= 1'b0;
    else if (cmd_i.fin) out_valid_o <= 1'b1;
    else if (!out_stall_i) out_valid_o <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      double_free_o    <= dfree;
      use_after_free_o <= uaf;
      guard_hits_o     <= guards_q;
      report_pc_o      <= pc_q;
      report_lr_o      <= lr_q;
      table_full_o     <= full_q;
      if (dfree) report_addr_o <= pf_obj_q;
      else if (uaf || guards_q != '0) report_addr_o <= wa_q;
      else report_addr_o <= '0;
    end
  end

endmodule

/* rtl/heap_misuse_monitor.sv */
// Heap misuse monitor.
// Input channel (in_valid_i / in_stall_o) carries one event per item: op,
// pc, link_reg, three argument registers and a write address. The result
// channel (out_valid_o / out_stall_i) returns exactly one report per event.
// Entry points are set through the cfg port (index, data, valid/ready);
// the user must set them only while the block is idle, which the block
// itself does not enforce. cfg_ready_o is always high.
// A block-start event or one that needs no table work goes from accept
// through plan and pick to finish, where the result is registered.
// Each table step walks one table one entry a cycle through its memory read
// port, ALLOC_ENTRIES or FREED_ENTRIES entries; a step that ends in an
// insert adds a write state. A completing release costs up to three
// freed/alloc walks, a completing realloc three, a checked write two.
// One event is processed at a time; the next item is taken as soon as the
// result is in the output register, even if the receiver still stalls it.
// A stalled result holds until taken; a further finished result waits.
// After reset, both tables are cleared one entry a cycle, with in_stall_o
// high until every entry of both tables is cleared.
module heap_misuse_monitor #(
  parameter int unsigned ALLOC_ENTRIES = 64,
  parameter int unsigned FREED_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [31:0] pc_i,
  input  logic [31:0] link_reg_i,
  input  logic [31:0] arg0_i,
  input  logic [31:0] arg1_i,
  input  logic [31:0] arg2_i,
  input  logic [31:0] write_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        double_free_o,
  output logic        use_after_free_o,
  output logic [6:0]  guard_hits_o,
  output logic [31:0] report_addr_o,
  output logic [31:0] report_pc_o,
  output logic [31:0] report_lr_o,
  output logic        table_full_o
);
  import hmm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  hmm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  hmm_datapath #(
    .ALLOC_ENTRIES (ALLOC_ENTRIES),
    .FREED_ENTRIES (FREED_ENTRIES)
  ) u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .stat_o (stat),
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .op_i, .pc_i, .link_reg_i, .arg0_i, .arg1_i, .arg2_i, .write_addr_i,
    .out_stall_i, .out_valid_o,
    .double_free_o, .use_after_free_o, .guard_hits_o,
    .report_addr_o, .report_pc_o, .report_lr_o, .table_full_o
  );

endmodule

/* rtl/hmm_checker.sv */
module hmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        double_free_o,
  input logic        use_after_free_o,
  input logic [6:0]  guard_hits_o,
  input logic [31:0] report_addr_o,
  input logic        table_full_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result dropped");

  // one event at a time: accepting blocks the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second item taken back to back");

  // a release report and a write report never share a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(double_free_o && (use_after_free_o || guard_hits_o != 7'd0)))
    else $error("mixed report kinds");

  // write checks never insert, so never overflow a table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (use_after_free_o || guard_hits_o != 7'd0) |-> !table_full_o)
    else $error("table full on a write event");

  // a report address only comes with a flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_addr_o != 32'd0 |->
      double_free_o || use_after_free_o || guard_hits_o != 7'd0)
    else $error("report address without a flag");

endmodule

bind heap_misuse_monitor hmm_checker u_hmm_checker (.*);
